### hw/rtl/ssd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ssd_pkg;

	localparam int CoordBits   = 16;
	localparam int FracBits    = 16;
	localparam int OutBits     = 17;
	localparam int DiffBits    = CoordBits + 1;
	localparam int DotBits     = 2 * DiffBits + 2;
	localparam int HalfBits    = (DotBits + 1) / 2;
	localparam int ProdBits    = 2 * DotBits;
	localparam int WideBits    = ProdBits + 1;
	localparam int RemBits     = WideBits + 1;
	localparam int QBits       = FracBits + 1;
	localparam int GapBits     = DiffBits + FracBits + 2;
	localparam int MagBits     = GapBits - 1;
	localparam int MagHalf     = (MagBits + 1) / 2;
	localparam int SqBits      = 2 * MagBits + 2;
	localparam int RootBits    = SqBits / 2;
	localparam int RootRemBits = RootBits + 2;

	typedef logic signed [CoordBits-1:0] coord_t;
	typedef logic signed [DiffBits-1:0]  diff_t;
	typedef logic signed [DotBits-1:0]   dot_t;
	typedef logic signed [ProdBits-1:0]  prod_t;
	typedef logic signed [WideBits-1:0]  wide_t;
	typedef logic [QBits-1:0]            frac_t;
	typedef logic [SqBits-1:0]           sq_t;
	typedef logic [RootBits-1:0]         root_t;
	typedef logic [OutBits-1:0]          dist_t;

	localparam frac_t FracOne = frac_t'(1) << FracBits;

	typedef struct packed {
		coord_t asx, asy, asz;
		coord_t aex, aey, aez;
		coord_t bsx, bsy, bsz;
		coord_t bex, bey, bez;
	} pair_t;

	typedef struct packed {
		diff_t ux, uy, uz;
		diff_t vx, vy, vz;
		diff_t wx, wy, wz;
	} vec_t;

endpackage
`default_nettype wire

### hw/rtl/ssd_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
interface ssd_pair_if;
	logic valid;
	logic ready;
	ssd_pkg::coord_t seg_a_start_x, seg_a_start_y, seg_a_start_z;
	ssd_pkg::coord_t seg_a_end_x, seg_a_end_y, seg_a_end_z;
	ssd_pkg::coord_t seg_b_start_x, seg_b_start_y, seg_b_start_z;
	ssd_pkg::coord_t seg_b_end_x, seg_b_end_y, seg_b_end_z;
	modport source(output valid, seg_a_start_x, seg_a_start_y, seg_a_start_z,
		seg_a_end_x, seg_a_end_y, seg_a_end_z, seg_b_start_x, seg_b_start_y,
		seg_b_start_z, seg_b_end_x, seg_b_end_y, seg_b_end_z, input ready);
	modport sink(input valid, seg_a_start_x, seg_a_start_y, seg_a_start_z,
		seg_a_end_x, seg_a_end_y, seg_a_end_z, seg_b_start_x, seg_b_start_y,
		seg_b_start_z, seg_b_end_x, seg_b_end_y, seg_b_end_z, output ready);
endinterface

interface ssd_dist_if;
	logic valid;
	logic ready;
	ssd_pkg::dist_t gap_distance;
	modport source(output valid, gap_distance, input ready);
	modport sink(input valid, gap_distance, output ready);
endinterface
`default_nettype wire

### hw/rtl/ssd_front.sv
`timescale 1ns / 1ps
`default_nettype none
module ssd_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  ssd_pkg::pair_t  pair,
	output logic            out_vld,
	output ssd_pkg::wide_t  sn,
	output ssd_pkg::wide_t  sd,
	output ssd_pkg::wide_t  tn,
	output ssd_pkg::wide_t  td,
	output ssd_pkg::vec_t   vec
);
	localparam int LoBits = ssd_pkg::DotBits + ssd_pkg::HalfBits + 1;
	localparam int HiBits = 2 * ssd_pkg::DotBits - ssd_pkg::HalfBits;

	typedef logic signed [LoBits-1:0] plo_t;
	typedef logic signed [HiBits-1:0] phi_t;
	typedef logic signed [ssd_pkg::DotBits:0] nd_t;

	function automatic ssd_pkg::dot_t dot3(input ssd_pkg::diff_t p0, p1, p2,
		input ssd_pkg::diff_t q0, q1, q2);
		dot3 = ssd_pkg::dot_t'(p0) * ssd_pkg::dot_t'(q0)
			+ ssd_pkg::dot_t'(p1) * ssd_pkg::dot_t'(q1)
			+ ssd_pkg::dot_t'(p2) * ssd_pkg::dot_t'(q2);
	endfunction

	function automatic plo_t mul_lo(input ssd_pkg::dot_t x, input ssd_pkg::dot_t y);
		mul_lo = plo_t'(x) * plo_t'($signed({1'b0, y[ssd_pkg::HalfBits-1:0]}));
	endfunction

	function automatic phi_t mul_hi(input ssd_pkg::dot_t x, input ssd_pkg::dot_t y);
		mul_hi = phi_t'(x) * phi_t'($signed(y[ssd_pkg::DotBits-1:ssd_pkg::HalfBits]));
	endfunction

	function automatic ssd_pkg::prod_t join_p(input phi_t h, input plo_t l);
		join_p = (ssd_pkg::prod_t'(h) <<< ssd_pkg::HalfBits) + ssd_pkg::prod_t'(l);
	endfunction

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	ssd_pkg::vec_t vec_s1, vec_s2, vec_s3, vec_s4, vec_s5, vec_s6, vec_s7;
	ssd_pkg::dot_t a_s2, b_s2, c_s2, d_s2, e_s2;
	ssd_pkg::dot_t a_s3, b_s3, c_s3, d_s3, e_s3;
	ssd_pkg::dot_t a_s4, b_s4, c_s4, d_s4, e_s4;
	ssd_pkg::dot_t a_s5, b_s5, c_s5, d_s5, e_s5;
	ssd_pkg::dot_t a_s6, b_s6, d_s6;
	plo_t acl_s3, bbl_s3, bel_s3, cdl_s3, ael_s3, bdl_s3;
	phi_t ach_s3, bbh_s3, beh_s3, cdh_s3, aeh_s3, bdh_s3;
	ssd_pkg::prod_t ac_s4, bb_s4, be_s4, cd_s4, ae_s4, bd_s4;
	ssd_pkg::wide_t dd_s5, snr_s5, tnr_s5;
	ssd_pkg::wide_t sn_s6, sd_s6, tn_s6, td_s6;
	ssd_pkg::wide_t sn_s7, sd_s7, tn_s7, td_s7;
	ssd_pkg::wide_t sn_c6, sd_c6, tn_c6, td_c6;
	ssd_pkg::wide_t sn_c7, sd_c7, tn_c7;
	nd_t nd_c7;
	logic fix_c7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// s clamp: parallel case falls back to sn = 0
	always_comb begin
		if (!(dd_s5 > 0)) begin
			sn_c6 = '0;
			sd_c6 = ssd_pkg::wide_t'(1);
			tn_c6 = ssd_pkg::wide_t'(e_s5);
			td_c6 = ssd_pkg::wide_t'(c_s5);
		end else begin
			sd_c6 = dd_s5;
			td_c6 = dd_s5;
			sn_c6 = snr_s5;
			tn_c6 = tnr_s5;
			if (snr_s5 < 0) begin
				sn_c6 = '0;
				tn_c6 = ssd_pkg::wide_t'(e_s5);
				td_c6 = ssd_pkg::wide_t'(c_s5);
			end else if (snr_s5 > dd_s5) begin
				sn_c6 = dd_s5;
				tn_c6 = ssd_pkg::wide_t'(e_s5) + ssd_pkg::wide_t'(b_s5);
				td_c6 = ssd_pkg::wide_t'(c_s5);
			end
		end
	end

	// t clamp, then recompute s against the clamped t
	always_comb begin
		sn_c7 = sn_s6;
		sd_c7 = sd_s6;
		tn_c7 = tn_s6;
		nd_c7 = '0;
		fix_c7 = 1'b0;
		if (tn_s6 < 0) begin
			tn_c7 = '0;
			nd_c7 = -nd_t'(d_s6);
			fix_c7 = 1'b1;
		end else if (tn_s6 > td_s6) begin
			tn_c7 = td_s6;
			nd_c7 = nd_t'(b_s6) - nd_t'(d_s6);
			fix_c7 = 1'b1;
		end
		if (fix_c7) begin
			if (nd_c7 < 0) begin
				sn_c7 = '0;
			end else if (nd_c7 > nd_t'(a_s6)) begin
				sn_c7 = sd_s6;
			end else begin
				sn_c7 = ssd_pkg::wide_t'(nd_c7);
				sd_c7 = ssd_pkg::wide_t'(a_s6);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1.ux <= ssd_pkg::diff_t'(pair.aex) - ssd_pkg::diff_t'(pair.asx);
			vec_s1.uy <= ssd_pkg::diff_t'(pair.aey) - ssd_pkg::diff_t'(pair.asy);
			vec_s1.uz <= ssd_pkg::diff_t'(pair.aez) - ssd_pkg::diff_t'(pair.asz);
			vec_s1.vx <= ssd_pkg::diff_t'(pair.bex) - ssd_pkg::diff_t'(pair.bsx);
			vec_s1.vy <= ssd_pkg::diff_t'(pair.bey) - ssd_pkg::diff_t'(pair.bsy);
			vec_s1.vz <= ssd_pkg::diff_t'(pair.bez) - ssd_pkg::diff_t'(pair.bsz);
			vec_s1.wx <= ssd_pkg::diff_t'(pair.asx) - ssd_pkg::diff_t'(pair.bsx);
			vec_s1.wy <= ssd_pkg::diff_t'(pair.asy) - ssd_pkg::diff_t'(pair.bsy);
			vec_s1.wz <= ssd_pkg::diff_t'(pair.asz) - ssd_pkg::diff_t'(pair.bsz);

			a_s2 <= dot3(vec_s1.ux, vec_s1.uy, vec_s1.uz, vec_s1.ux, vec_s1.uy, vec_s1.uz);
			b_s2 <= dot3(vec_s1.ux, vec_s1.uy, vec_s1.uz, vec_s1.vx, vec_s1.vy, vec_s1.vz);
			c_s2 <= dot3(vec_s1.vx, vec_s1.vy, vec_s1.vz, vec_s1.vx, vec_s1.vy, vec_s1.vz);
			d_s2 <= dot3(vec_s1.ux, vec_s1.uy, vec_s1.uz, vec_s1.wx, vec_s1.wy, vec_s1.wz);
			e_s2 <= dot3(vec_s1.vx, vec_s1.vy, vec_s1.vz, vec_s1.wx, vec_s1.wy, vec_s1.wz);
			vec_s2 <= vec_s1;

			// wide products in two halves of the second operand
			acl_s3 <= mul_lo(a_s2, c_s2);
			ach_s3 <= mul_hi(a_s2, c_s2);
			bbl_s3 <= mul_lo(b_s2, b_s2);
			bbh_s3 <= mul_hi(b_s2, b_s2);
			bel_s3 <= mul_lo(b_s2, e_s2);
			beh_s3 <= mul_hi(b_s2, e_s2);
			cdl_s3 <= mul_lo(c_s2, d_s2);
			cdh_s3 <= mul_hi(c_s2, d_s2);
			ael_s3 <= mul_lo(a_s2, e_s2);
			aeh_s3 <= mul_hi(a_s2, e_s2);
			bdl_s3 <= mul_lo(b_s2, d_s2);
			bdh_s3 <= mul_hi(b_s2, d_s2);
			{a_s3, b_s3, c_s3, d_s3, e_s3} <= {a_s2, b_s2, c_s2, d_s2, e_s2};
			vec_s3 <= vec_s2;

			ac_s4 <= join_p(ach_s3, acl_s3);
			bb_s4 <= join_p(bbh_s3, bbl_s3);
			be_s4 <= join_p(beh_s3, bel_s3);
			cd_s4 <= join_p(cdh_s3, cdl_s3);
			ae_s4 <= join_p(aeh_s3, ael_s3);
			bd_s4 <= join_p(bdh_s3, bdl_s3);
			{a_s4, b_s4, c_s4, d_s4, e_s4} <= {a_s3, b_s3, c_s3, d_s3, e_s3};
			vec_s4 <= vec_s3;

			dd_s5 <= ssd_pkg::wide_t'(ac_s4) - ssd_pkg::wide_t'(bb_s4);
			snr_s5 <= ssd_pkg::wide_t'(be_s4) - ssd_pkg::wide_t'(cd_s4);
			tnr_s5 <= ssd_pkg::wide_t'(ae_s4) - ssd_pkg::wide_t'(bd_s4);
			{a_s5, b_s5, c_s5, d_s5, e_s5} <= {a_s4, b_s4, c_s4, d_s4, e_s4};
			vec_s5 <= vec_s4;

			sn_s6 <= sn_c6;
			sd_s6 <= sd_c6;
			tn_s6 <= tn_c6;
			td_s6 <= td_c6;
			{a_s6, b_s6, d_s6} <= {a_s5, b_s5, d_s5};
			vec_s6 <= vec_s5;

			sn_s7 <= sn_c7;
			sd_s7 <= sd_c7;
			tn_s7 <= tn_c7;
			td_s7 <= td_s6;
			vec_s7 <= vec_s6;
		end
	end

	assign out_vld = vld_s7;
	assign sn = sn_s7;
	assign sd = sd_s7;
	assign tn = tn_s7;
	assign td = td_s7;
	assign vec = vec_s7;
endmodule
`default_nettype wire

### hw/rtl/ssd_frac_div.sv
`timescale 1ns / 1ps
`default_nettype none
module ssd_frac_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  ssd_pkg::wide_t  sn,
	input  ssd_pkg::wide_t  sd,
	input  ssd_pkg::wide_t  tn,
	input  ssd_pkg::wide_t  td,
	input  ssd_pkg::vec_t   vec_in,
	output logic            out_vld,
	output ssd_pkg::frac_t  sc,
	output ssd_pkg::frac_t  tc,
	output ssd_pkg::vec_t   vec_out
);
	localparam int Steps = ssd_pkg::QBits;

	typedef logic [ssd_pkg::RemBits-1:0] rem_t;

	logic           vld_s [Steps+1];
	rem_t           srem_s [Steps+1];
	rem_t           sden_s [Steps+1];
	rem_t           trem_s [Steps+1];
	rem_t           tden_s [Steps+1];
	ssd_pkg::frac_t sq_s [Steps+1];
	ssd_pkg::frac_t tq_s [Steps+1];
	ssd_pkg::vec_t  vec_s [Steps+1];

	logic s_zero, t_zero;

	// Numerator never exceeds denominator after the clamps, so a zero
	// case becomes 0 / 1 and runs through the same steps.
	assign s_zero = !(sn > 0) || !(sd > 0);
	assign t_zero = !(tn > 0) || !(td > 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			srem_s[0] <= s_zero ? '0 : rem_t'(unsigned'(sn));
			sden_s[0] <= s_zero ? rem_t'(1) : rem_t'(unsigned'(sd));
			trem_s[0] <= t_zero ? '0 : rem_t'(unsigned'(tn));
			tden_s[0] <= t_zero ? rem_t'(1) : rem_t'(unsigned'(td));
			sq_s[0] <= '0;
			tq_s[0] <= '0;
			vec_s[0] <= vec_in;
		end
	end

	for (genvar j = 0; j < Steps; j++) begin : g_step
		logic s_ge, t_ge;
		rem_t s_left, t_left;

		assign s_ge = srem_s[j] >= sden_s[j];
		assign t_ge = trem_s[j] >= tden_s[j];
		assign s_left = s_ge ? srem_s[j] - sden_s[j] : srem_s[j];
		assign t_left = t_ge ? trem_s[j] - tden_s[j] : trem_s[j];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				srem_s[j+1] <= s_left << 1;
				trem_s[j+1] <= t_left << 1;
				sden_s[j+1] <= sden_s[j];
				tden_s[j+1] <= tden_s[j];
				sq_s[j+1] <= {sq_s[j][ssd_pkg::QBits-2:0], s_ge};
				tq_s[j+1] <= {tq_s[j][ssd_pkg::QBits-2:0], t_ge};
				vec_s[j+1] <= vec_s[j];
			end
		end
	end

	assign out_vld = vld_s[Steps];
	assign sc = sq_s[Steps];
	assign tc = tq_s[Steps];
	assign vec_out = vec_s[Steps];
endmodule
`default_nettype wire

### hw/rtl/ssd_gap.sv
`timescale 1ns / 1ps
`default_nettype none
module ssd_gap (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  ssd_pkg::frac_t  sc,
	input  ssd_pkg::frac_t  tc,
	input  ssd_pkg::vec_t   vec,
	output logic            out_vld,
	output ssd_pkg::sq_t    sum
);
	localparam int MH = ssd_pkg::MagHalf;
	localparam int MB = ssd_pkg::MagBits;

	typedef logic signed [ssd_pkg::GapBits-1:0] gap_t;
	typedef logic [MB-1:0] mag_t;
	typedef logic [2*MH-1:0] part_t;

	ssd_pkg::diff_t u [3];
	ssd_pkg::diff_t v [3];
	ssd_pkg::diff_t w [3];
	gap_t  pu_s1 [3];
	gap_t  pv_s1 [3];
	gap_t  ws_s1 [3];
	gap_t  g_s2 [3];
	mag_t  mag [3];
	part_t ll_s3 [3];
	part_t lh_s3 [3];
	part_t hh_s3 [3];
	ssd_pkg::sq_t sq_s4 [3];
	ssd_pkg::sq_t sum_s5;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	assign u[0] = vec.ux;
	assign u[1] = vec.uy;
	assign u[2] = vec.uz;
	assign v[0] = vec.vx;
	assign v[1] = vec.vy;
	assign v[2] = vec.vz;
	assign w[0] = vec.wx;
	assign w[1] = vec.wy;
	assign w[2] = vec.wz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_axis
		gap_t g_abs;

		assign g_abs = (g_s2[k] < 0) ? -g_s2[k] : g_s2[k];
		assign mag[k] = g_abs[MB-1:0];

		always_ff @(posedge clk) begin
			if (en) begin
				pu_s1[k] <= gap_t'(u[k]) * gap_t'($signed({1'b0, sc}));
				pv_s1[k] <= gap_t'(v[k]) * gap_t'($signed({1'b0, tc}));
				ws_s1[k] <= gap_t'(w[k]) <<< ssd_pkg::FracBits;

				g_s2[k] <= ws_s1[k] + pu_s1[k] - pv_s1[k];

				// square from halves of the magnitude
				ll_s3[k] <= part_t'(mag[k][MH-1:0]) * part_t'(mag[k][MH-1:0]);
				lh_s3[k] <= part_t'(mag[k][MH-1:0]) * part_t'(mag[k][MB-1:MH]);
				hh_s3[k] <= part_t'(mag[k][MB-1:MH]) * part_t'(mag[k][MB-1:MH]);

				sq_s4[k] <= (ssd_pkg::sq_t'(hh_s3[k]) << (2 * MH))
					+ (ssd_pkg::sq_t'(lh_s3[k]) << (MH + 1))
					+ ssd_pkg::sq_t'(ll_s3[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s5 <= sq_s4[0] + sq_s4[1] + sq_s4[2];
		end
	end

	assign out_vld = vld_s5;
	assign sum = sum_s5;
endmodule
`default_nettype wire

### hw/rtl/ssd_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module ssd_isqrt (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  ssd_pkg::sq_t    rad,
	output logic            out_vld,
	output ssd_pkg::root_t  root
);
	localparam int Steps = ssd_pkg::RootBits;

	typedef logic [ssd_pkg::RootRemBits-1:0] rrem_t;

	logic           vld_s [Steps+1];
	ssd_pkg::sq_t   rad_s [Steps+1];
	rrem_t          rem_s [Steps+1];
	ssd_pkg::root_t root_s [Steps+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s[0] <= rad;
			rem_s[0] <= '0;
			root_s[0] <= '0;
		end
	end

	// one root bit per stage: bring down two radicand bits, try 4r+1
	for (genvar j = 0; j < Steps; j++) begin : g_step
		rrem_t nxt, trial;
		logic  ge;

		assign nxt = {rem_s[j][ssd_pkg::RootRemBits-3:0],
			rad_s[j][ssd_pkg::SqBits-1 -: 2]};
		assign trial = {root_s[j], 2'b01};
		assign ge = nxt >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[j+1] <= rad_s[j] << 2;
				rem_s[j+1] <= ge ? nxt - trial : nxt;
				root_s[j+1] <= {root_s[j][ssd_pkg::RootBits-2:0], ge};
			end
		end
	end

	assign out_vld = vld_s[Steps];
	assign root = root_s[Steps];
endmodule
`default_nettype wire

### hw/rtl/segment_segment_distance_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Item
// pairs     in   two segments, twelve signed Q12.4 end point coordinates
// gaps      out  gap_distance, unsigned Q13.4, floor of the shortest distance
//
// One pair enters per cycle while gaps is not stalled; the pipeline has 7 geometry
// and clamp stages, 18 divider stages, 5 gap stages, 36 square root stages, 1 output.
// The two 17-step dividers and the 35-step square root set the depth.
// Reset clears only the valid bits. A stall on gaps freezes every stage at
// once, so nothing is lost or repeated.
module segment_segment_distance_top (
	input  logic        clk,
	input  logic        arst_n,
	ssd_pair_if.sink    pairs,
	ssd_dist_if.source  gaps
);
	logic            en;
	ssd_pkg::pair_t  pair;
	logic            fr_vld;
	ssd_pkg::wide_t  sn, sd, tn, td;
	ssd_pkg::vec_t   fr_vec, dv_vec;
	logic            dv_vld;
	ssd_pkg::frac_t  sc, tc;
	logic            gp_vld;
	ssd_pkg::sq_t    sum;
	logic            rt_vld;
	ssd_pkg::root_t  root;
	logic [ssd_pkg::RootBits-ssd_pkg::FracBits-1:0] whole;
	logic            vld_q;
	ssd_pkg::dist_t  gap_q;

	// advance only when the output register is free or being drained
	assign en = !vld_q || gaps.ready;
	assign pairs.ready = en;

	assign pair.asx = pairs.seg_a_start_x;
	assign pair.asy = pairs.seg_a_start_y;
	assign pair.asz = pairs.seg_a_start_z;
	assign pair.aex = pairs.seg_a_end_x;
	assign pair.aey = pairs.seg_a_end_y;
	assign pair.aez = pairs.seg_a_end_z;
	assign pair.bsx = pairs.seg_b_start_x;
	assign pair.bsy = pairs.seg_b_start_y;
	assign pair.bsz = pairs.seg_b_start_z;
	assign pair.bex = pairs.seg_b_end_x;
	assign pair.bey = pairs.seg_b_end_y;
	assign pair.bez = pairs.seg_b_end_z;

	ssd_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(pairs.valid), .pair(pair),
		.out_vld(fr_vld), .sn(sn), .sd(sd), .tn(tn), .td(td), .vec(fr_vec)
	);

	ssd_frac_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(fr_vld),
		.sn(sn), .sd(sd), .tn(tn), .td(td), .vec_in(fr_vec),
		.out_vld(dv_vld), .sc(sc), .tc(tc), .vec_out(dv_vec)
	);

	ssd_gap u_gap (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(dv_vld),
		.sc(sc), .tc(tc), .vec(dv_vec), .out_vld(gp_vld), .sum(sum)
	);

	ssd_isqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(gp_vld), .rad(sum),
		.out_vld(rt_vld), .root(root)
	);

	assign whole = root[ssd_pkg::RootBits-1:ssd_pkg::FracBits];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= rt_vld;
		end
	end

	// saturate to the output width
	always_ff @(posedge clk) begin
		if (en) begin
			if (whole > {{(ssd_pkg::RootBits-ssd_pkg::FracBits-ssd_pkg::OutBits){1'b0}},
				{ssd_pkg::OutBits{1'b1}}}) begin
				gap_q <= '1;
			end else begin
				gap_q <= whole[ssd_pkg::OutBits-1:0];
			end
		end
	end

	assign gaps.valid = vld_q;
	assign gaps.gap_distance = gap_q;

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		dv_vld |-> (sc <= ssd_pkg::FracOne && tc <= ssd_pkg::FracOne))
		else $error("segment fraction above one");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!pairs.ready |-> gaps.valid)
		else $error("input stalled with no item waiting at the output");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(rt_vld && en) |=> gaps.valid)
		else $error("finished item did not reach the output register");
endmodule
`default_nettype wire

### tb/ssd_tb_ifs.sv
`timescale 1ns / 1ps
// Channel interfaces come from the RTL; this file holds the scoreboard class shared by the bench.
package ssd_tb_pkg;
	import ssd_pkg::*;

	class dist_scoreboard;
		dist_t pending_dist[$];
		int    mismatch_count;
		int    stray_count;

		function new();
			mismatch_count = 0;
			stray_count = 0;
		endfunction

		function void note_pair(dist_t predicted);
			pending_dist.push_back(predicted);
		endfunction

		function void check_dist(dist_t actual);
			dist_t wanted;
			if (pending_dist.size() == 0) begin
				stray_count++;
				if (mismatch_count + stray_count <= 10)
					$display("unexpected distance %0d", actual);
				return;
			end
			wanted = pending_dist.pop_front();
			if (wanted !== actual) begin
				mismatch_count++;
				if (mismatch_count + stray_count <= 10)
					$display("distance mismatch: expected %0d got %0d", wanted, actual);
			end
		endfunction
	endclass
endpackage

### tb/tb_segment_segment_distance_top.sv
`timescale 1ns / 1ps
module tb_segment_segment_distance_top;
	import ssd_pkg::*;
	import ssd_tb_pkg::*;

	localparam int PipeDepth = 67;

	typedef logic signed [127:0] big_t;

	logic clk;
	logic arst_n;
	ssd_pair_if pairs();
	ssd_dist_if gaps();

	segment_segment_distance_top i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.pairs (pairs.sink),
		.gaps  (gaps.source)
	);

	dist_scoreboard scoreboard = new();
	bit no_idle;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("CHECKS FAILED");
		$finish;
	end

	// floor(num * 2^16 / den), clamped to one; zero when either side is not positive
	function automatic big_t param_frac(big_t num, big_t den);
		big_t q;
		if (num <= 0 || den <= 0)
			return 0;
		q = (num <<< FracBits) / den;
		if (q > (big_t'(1) <<< FracBits))
			q = big_t'(1) <<< FracBits;
		return q;
	endfunction

	function automatic big_t isqrt_floor(big_t s);
		big_t r, t;
		r = 0;
		for (int i = 63; i >= 0; i--) begin
			t = r | (big_t'(1) <<< i);
			if (t * t <= s)
				r = t;
		end
		return r;
	endfunction

	function automatic dist_t closest_gap(pair_t p);
		big_t u[3], v[3], w[3];
		big_t a, b, c, d, e, dd, sn, sd, tn, td, nd, sc, tc, g, sum, r;
		bit reclamp;
		u[0] = big_t'(p.aex) - big_t'(p.asx);
		u[1] = big_t'(p.aey) - big_t'(p.asy);
		u[2] = big_t'(p.aez) - big_t'(p.asz);
		v[0] = big_t'(p.bex) - big_t'(p.bsx);
		v[1] = big_t'(p.bey) - big_t'(p.bsy);
		v[2] = big_t'(p.bez) - big_t'(p.bsz);
		w[0] = big_t'(p.asx) - big_t'(p.bsx);
		w[1] = big_t'(p.asy) - big_t'(p.bsy);
		w[2] = big_t'(p.asz) - big_t'(p.bsz);
		a = u[0]*u[0] + u[1]*u[1] + u[2]*u[2];
		b = u[0]*v[0] + u[1]*v[1] + u[2]*v[2];
		c = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
		d = u[0]*w[0] + u[1]*w[1] + u[2]*w[2];
		e = v[0]*w[0] + v[1]*w[1] + v[2]*w[2];
		dd = a*c - b*b;
		if (dd <= 0) begin
			sn = 0; sd = 1; tn = e; td = c;
		end else begin
			sd = dd; td = dd;
			sn = b*e - c*d;
			tn = a*e - b*d;
			if (sn < 0) begin
				sn = 0; tn = e; td = c;
			end else if (sn > sd) begin
				sn = sd; tn = e + b; td = c;
			end
		end
		reclamp = 1'b1;
		nd = 0;
		if (tn < 0) begin
			tn = 0; nd = -d;
		end else if (tn > td) begin
			tn = td; nd = b - d;
		end else begin
			reclamp = 1'b0;
		end
		if (reclamp) begin
			if (nd < 0)
				sn = 0;
			else if (nd > a)
				sn = sd;
			else begin
				sn = nd; sd = a;
			end
		end
		sc = param_frac(sn, sd);
		tc = param_frac(tn, td);
		sum = 0;
		for (int k = 0; k < 3; k++) begin
			g = (w[k] <<< FracBits) + u[k]*sc - v[k]*tc;
			sum += g*g;
		end
		r = isqrt_floor(sum) >>> FracBits;
		if (r > (big_t'(1) <<< OutBits) - 1)
			r = (big_t'(1) <<< OutBits) - 1;
		return dist_t'(r);
	endfunction

	function automatic coord_t pick_coord(int mode);
		case (mode)
			0: return coord_t'($urandom);
			1: return coord_t'($urandom_range(0, 64) - 32);
			2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			default: return coord_t'($urandom_range(0, 2000) - 1000);
		endcase
	endfunction

	task automatic send_pair(pair_t p);
		while (!no_idle && $urandom_range(0, 99) < 23) begin
			pairs.valid <= 1'b0;
			@(posedge clk);
		end
		pairs.valid <= 1'b1;
		{pairs.seg_a_start_x, pairs.seg_a_start_y, pairs.seg_a_start_z,
		 pairs.seg_a_end_x, pairs.seg_a_end_y, pairs.seg_a_end_z,
		 pairs.seg_b_start_x, pairs.seg_b_start_y, pairs.seg_b_start_z,
		 pairs.seg_b_end_x, pairs.seg_b_end_y, pairs.seg_b_end_z} <= p;
		do @(posedge clk); while (!pairs.ready);
		scoreboard.note_pair(closest_gap(p));
	endtask

	task automatic send_random(int mode);
		pair_t p;
		int    shape;
		shape = $urandom_range(0, 5);
		p.asx = pick_coord(mode); p.asy = pick_coord(mode); p.asz = pick_coord(mode);
		p.aex = pick_coord(mode); p.aey = pick_coord(mode); p.aez = pick_coord(mode);
		p.bsx = pick_coord(mode); p.bsy = pick_coord(mode); p.bsz = pick_coord(mode);
		p.bex = pick_coord(mode); p.bey = pick_coord(mode); p.bez = pick_coord(mode);
		case (shape)
			// near parallel: the edge of segment b is the edge of segment a halved, truncated toward zero
			0: begin
				p.bex = coord_t'(p.bsx + (p.aex - p.asx) / 2);
				p.bey = coord_t'(p.bsy + (p.aey - p.asy) / 2);
				p.bez = coord_t'(p.bsz + (p.aez - p.asz) / 2);
			end
			1: begin
				p.aex = p.asx; p.aey = p.asy; p.aez = p.asz;
			end
			2: begin
				p.bex = p.bsx; p.bey = p.bsy; p.bez = p.bsz;
			end
			default: ;
		endcase
		send_pair(p);
	endtask

	task automatic send_all_same(coord_t value);
		pair_t p;
		p = {12{value}};
		send_pair(p);
	endtask

	initial begin
		pair_t p;
		arst_n = 1'b0;
		no_idle = 1'b0;
		pairs.valid = 1'b0;
		{pairs.seg_a_start_x, pairs.seg_a_start_y, pairs.seg_a_start_z,
		 pairs.seg_a_end_x, pairs.seg_a_end_y, pairs.seg_a_end_z,
		 pairs.seg_b_start_x, pairs.seg_b_start_y, pairs.seg_b_start_z,
		 pairs.seg_b_end_x, pairs.seg_b_end_y, pairs.seg_b_end_z} = '0;
		gaps.ready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_all_same(16'sh0000);
		send_all_same(16'sh7fff);
		send_all_same(16'sh8000);
		// opposite corners: full extent edges, then two points
		p = {16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff,
		     16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff};
		send_pair(p);
		p = {16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
		     16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
		send_pair(p);
		// parallel and collinear
		p = {16'sd0, 16'sd0, 16'sd0, 16'sd160, 16'sd0, 16'sd0,
		     16'sd0, 16'sd32, 16'sd0, 16'sd320, 16'sd32, 16'sd0};
		send_pair(p);
		p = {16'sd0, 16'sd0, 16'sd0, 16'sd160, 16'sd0, 16'sd0,
		     16'sd320, 16'sd0, 16'sd0, 16'sd480, 16'sd0, 16'sd0};
		send_pair(p);
		p = {16'sd0, 16'sd0, 16'sd0, 16'sd160, 16'sd0, 16'sd0,
		     -16'sd320, 16'sd0, 16'sd0, -16'sd480, 16'sd0, 16'sd0};
		send_pair(p);
		// crossing, skew, and both clamp ends
		p = {-16'sd80, 16'sd0, 16'sd0, 16'sd80, 16'sd0, 16'sd0,
		     16'sd0, -16'sd80, 16'sd16, 16'sd0, 16'sd80, 16'sd16};
		send_pair(p);
		p = {16'sd0, 16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd0,
		     16'sd200, -16'sd80, 16'sd16, 16'sd200, 16'sd80, 16'sd16};
		send_pair(p);
		p = {16'sd0, 16'sd0, 16'sd0, 16'sd16, 16'sd0, 16'sd0,
		     -16'sd200, -16'sd80, 16'sd16, -16'sd200, 16'sd80, 16'sd16};
		send_pair(p);
		p = {16'sd0, 16'sd0, 16'sd0, 16'sd160, 16'sd0, 16'sd0,
		     16'sd80, 16'sd300, 16'sd5, 16'sd80, 16'sd200, 16'sd5};
		send_pair(p);
		// point against point, point against segment
		p = {16'sd3, 16'sd4, 16'sd0, 16'sd3, 16'sd4, 16'sd0,
		     16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
		send_pair(p);
		p = {16'sd50, 16'sd50, 16'sd50, 16'sd50, 16'sd50, 16'sd50,
		     16'sd0, 16'sd0, 16'sd0, 16'sd160, 16'sd0, 16'sd0};
		send_pair(p);
		p = {16'sd0, 16'sd0, 16'sd0, 16'sd160, 16'sd0, 16'sd0,
		     16'sd50, 16'sd50, 16'sd50, 16'sd50, 16'sd50, 16'sd50};
		send_pair(p);

		// hold off until the pipe drains
		pairs.valid <= 1'b0;
		while (scoreboard.pending_dist.size() != 0)
			@(posedge clk);

		for (int n = 0; n < 935; n++) begin
			no_idle = (n >= 400 && n < 550);
			send_random($urandom_range(0, 3));
		end
		pairs.valid <= 1'b0;
		no_idle = 1'b0;

		while (scoreboard.pending_dist.size() != 0)
			@(posedge clk);
		repeat (PipeDepth + 10) @(posedge clk);
		if (scoreboard.mismatch_count == 0 && scoreboard.stray_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			gaps.ready <= no_idle || ($urandom_range(0, 99) >= 23);
			if (gaps.valid && gaps.ready)
				scoreboard.check_dist(gaps.gap_distance);
		end
	end
endmodule
